// ----- design/lcp_pkg.sv -----
package lcp_pkg;

	localparam int COORD_W   = 32;
	localparam int DIR_W     = 18;
	localparam int THR_W     = 17;
	localparam int THR_SHIFT = 16;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(65470);

	// Exact integer widths of the geometry terms.
	localparam int PROD_W  = 2 * DIR_W;
	localparam int DOT_W   = PROD_W + 2;
	localparam int C_W     = PROD_W + 1;
	localparam int WC_W    = DIR_W + C_W;
	localparam int N2_W    = WC_W + 1;
	localparam int N2_LO_W = N2_W / 2;
	localparam int N2_HI_W = N2_W - N2_LO_W;
	localparam int BA_W    = COORD_W + 1;
	localparam int DEN_W   = DIR_W + N2_W + 2;
	localparam int NUM_W   = BA_W + N2_W + 2;
	localparam int NCH_W   = (NUM_W + 2) / 3;
	localparam int NCH_HI_W = NUM_W - 2 * NCH_W;
	localparam int P_W     = NUM_W + DIR_W;

	// Divider: one quotient bit per stage, quotient below 2^Q_BITS unless saturated.
	localparam int Q_BITS  = COORD_W + 1;
	localparam int DIV_W   = DEN_W + Q_BITS + 1;
	localparam int SUM_W   = COORD_W + 3;

	localparam int LATENCY = Q_BITS + 13;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_PARALLEL = 2'd1,
		ST_ZERO_DIV = 2'd2,
		ST_SAT      = 2'd3
	} status_t;

	typedef struct {
		logic                      valid;
		logic                      par;
		logic signed [COORD_W-1:0] a [3];
		logic signed [DIR_W-1:0]   v [3];
		logic signed [DEN_W-1:0]   den;
		logic signed [NUM_W-1:0]   num;
	} front_t;

	typedef struct {
		logic                      valid;
		status_t                   rej;
		logic signed [COORD_W-1:0] a [3];
		logic                      neg [3];
		logic [P_W-1:0]            pmag [3];
		logic [DEN_W-1:0]          dmag;
	} scale_t;

	typedef struct {
		logic                      valid;
		logic signed [COORD_W-1:0] point [3];
		status_t                   status;
	} res_t;

endpackage

// ----- design/lcp_front.sv -----
module lcp_front import lcp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic signed [COORD_W-1:0] pos_a [3],
	input  logic signed [DIR_W-1:0]   dir_v [3],
	input  logic signed [COORD_W-1:0] pos_b [3],
	input  logic signed [DIR_W-1:0]   dir_w [3],
	input  logic [THR_W-1:0]          thr,
	output front_t                    f
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic signed [PROD_W-1:0]  vw_s1 [3][3];
	logic signed [BA_W-1:0]    ba_s1 [3], ba_s2 [3], ba_s3 [3], ba_s4 [3];
	logic signed [COORD_W-1:0] a_s1 [3], a_s2 [3], a_s3 [3], a_s4 [3], a_s5 [3], a_s6 [3],
		a_s7 [3];
	logic signed [DIR_W-1:0]   v_s1 [3], v_s2 [3], v_s3 [3], v_s4 [3], v_s5 [3], v_s6 [3],
		v_s7 [3];
	logic signed [DIR_W-1:0]   w_s1 [3], w_s2 [3];
	logic                      par_s2, par_s3, par_s4, par_s5, par_s6, par_s7;
	logic signed [C_W-1:0]     c_s2 [3];
	logic signed [WC_W-1:0]    wc_s3 [3][2];
	logic signed [N2_W-1:0]    n2_s4 [3];
	logic signed [DIR_W+N2_LO_W:0]   vlo_s5 [3];
	logic signed [DIR_W+N2_HI_W-1:0] vhi_s5 [3];
	logic signed [BA_W+N2_LO_W:0]    balo_s5 [3];
	logic signed [BA_W+N2_HI_W-1:0]  bahi_s5 [3];
	logic signed [DEN_W-1:0]   dent_s6 [3];
	logic signed [NUM_W-1:0]   numt_s6 [3];
	logic signed [DEN_W-1:0]   den_s7;
	logic signed [NUM_W-1:0]   num_s7;

	logic signed [DOT_W-1:0] dot;
	logic [DOT_W-1:0]        dot_mag;

	always_comb begin
		dot = DOT_W'(vw_s1[0][0]) + DOT_W'(vw_s1[1][1]) + DOT_W'(vw_s1[2][2]);
		dot_mag = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		// Stage 1: all direction products and the point difference.
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				vw_s1[i][j] <= PROD_W'(dir_v[i] * dir_w[j]);
			end
			ba_s1[i] <= BA_W'(pos_b[i]) - BA_W'(pos_a[i]);
		end
		a_s1 <= pos_a;
		v_s1 <= dir_v;
		w_s1 <= dir_w;

		// Stage 2: parallel test and c = v x w.
		par_s2 <= dot_mag > DOT_W'({thr, {THR_SHIFT{1'b0}}});
		c_s2[0] <= C_W'(vw_s1[1][2]) - C_W'(vw_s1[2][1]);
		c_s2[1] <= C_W'(vw_s1[2][0]) - C_W'(vw_s1[0][2]);
		c_s2[2] <= C_W'(vw_s1[0][1]) - C_W'(vw_s1[1][0]);
		a_s2 <= a_s1;
		v_s2 <= v_s1;
		w_s2 <= w_s1;
		ba_s2 <= ba_s1;

		// Stage 3: products for n2 = w x c.
		wc_s3[0][0] <= WC_W'(w_s2[1] * c_s2[2]);
		wc_s3[0][1] <= WC_W'(w_s2[2] * c_s2[1]);
		wc_s3[1][0] <= WC_W'(w_s2[2] * c_s2[0]);
		wc_s3[1][1] <= WC_W'(w_s2[0] * c_s2[2]);
		wc_s3[2][0] <= WC_W'(w_s2[0] * c_s2[1]);
		wc_s3[2][1] <= WC_W'(w_s2[1] * c_s2[0]);
		par_s3 <= par_s2;
		a_s3 <= a_s2;
		v_s3 <= v_s2;
		ba_s3 <= ba_s2;

		// Stage 4: n2.
		for (int i = 0; i < 3; i++) begin
			n2_s4[i] <= N2_W'(wc_s3[i][0]) - N2_W'(wc_s3[i][1]);
		end
		par_s4 <= par_s3;
		a_s4 <= a_s3;
		v_s4 <= v_s3;
		ba_s4 <= ba_s3;

		// Stage 5: n2 is split in halves so each multiplier stays narrow.
		for (int i = 0; i < 3; i++) begin
			vlo_s5[i]  <= v_s4[i] * $signed({1'b0, n2_s4[i][N2_LO_W-1:0]});
			vhi_s5[i]  <= v_s4[i] * $signed(n2_s4[i][N2_W-1:N2_LO_W]);
			balo_s5[i] <= ba_s4[i] * $signed({1'b0, n2_s4[i][N2_LO_W-1:0]});
			bahi_s5[i] <= ba_s4[i] * $signed(n2_s4[i][N2_W-1:N2_LO_W]);
		end
		par_s5 <= par_s4;
		a_s5 <= a_s4;
		v_s5 <= v_s4;

		// Stage 6: recombine the halves.
		for (int i = 0; i < 3; i++) begin
			dent_s6[i] <= (DEN_W'(vhi_s5[i]) <<< N2_LO_W) + DEN_W'(vlo_s5[i]);
			numt_s6[i] <= (NUM_W'(bahi_s5[i]) <<< N2_LO_W) + NUM_W'(balo_s5[i]);
		end
		par_s6 <= par_s5;
		a_s6 <= a_s5;
		v_s6 <= v_s5;

		// Stage 7: the two dot products with n2.
		den_s7 <= dent_s6[0] + dent_s6[1] + dent_s6[2];
		num_s7 <= numt_s6[0] + numt_s6[1] + numt_s6[2];
		par_s7 <= par_s6;
		a_s7 <= a_s6;
		v_s7 <= v_s6;
	end

	always_comb begin
		f.valid = vld_s7;
		f.par   = par_s7;
		f.a     = a_s7;
		f.v     = v_s7;
		f.den   = den_s7;
		f.num   = num_s7;
	end

endmodule

// ----- design/lcp_scale.sv -----
module lcp_scale import lcp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  front_t f,
	output scale_t s
);

	logic vld_s8, vld_s9, vld_s10;

	status_t rej_s8, rej_s9, rej_s10;
	logic signed [COORD_W-1:0] a_s8 [3], a_s9 [3], a_s10 [3];
	logic signed [DIR_W+NCH_W:0]      plo_s8 [3], pmid_s8 [3];
	logic signed [DIR_W+NCH_HI_W-1:0] phi_s8 [3];
	logic                      dneg_s8, dneg_s9;
	logic [DEN_W-1:0]          dmag_s8, dmag_s9, dmag_s10;
	logic signed [P_W-1:0]     p_s9 [3];
	logic                      neg_s10 [3];
	logic [P_W-1:0]            pmag_s10 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			vld_s8  <= f.valid;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		// Stage 8: reject test, sign and magnitude of den, and num times each direction component, in three chunks of num.
		if (f.par) begin
			rej_s8 <= ST_PARALLEL;
		end else if (f.den == '0) begin
			rej_s8 <= ST_ZERO_DIV;
		end else begin
			rej_s8 <= ST_OK;
		end
		for (int i = 0; i < 3; i++) begin
			plo_s8[i]  <= f.v[i] * $signed({1'b0, f.num[NCH_W-1:0]});
			pmid_s8[i] <= f.v[i] * $signed({1'b0, f.num[2*NCH_W-1:NCH_W]});
			phi_s8[i]  <= f.v[i] * $signed(f.num[NUM_W-1:2*NCH_W]);
		end
		dneg_s8 <= f.den[DEN_W-1];
		dmag_s8 <= f.den[DEN_W-1] ? DEN_W'(-f.den) : DEN_W'(f.den);
		a_s8 <= f.a;

		// Stage 9: full product.
		for (int i = 0; i < 3; i++) begin
			p_s9[i] <= (P_W'(phi_s8[i]) <<< (2 * NCH_W)) + (P_W'(pmid_s8[i]) <<< NCH_W)
				+ P_W'(plo_s8[i]);
		end
		rej_s9 <= rej_s8;
		dneg_s9 <= dneg_s8;
		dmag_s9 <= dmag_s8;
		a_s9 <= a_s8;

		// Stage 10: sign and magnitude for the divider.
		for (int i = 0; i < 3; i++) begin
			neg_s10[i]  <= p_s9[i][P_W-1] ^ dneg_s9;
			pmag_s10[i] <= p_s9[i][P_W-1] ? P_W'(-p_s9[i]) : P_W'(p_s9[i]);
		end
		rej_s10 <= rej_s9;
		dmag_s10 <= dmag_s9;
		a_s10 <= a_s9;
	end

	always_comb begin
		s.valid = vld_s10;
		s.rej   = rej_s10;
		s.a     = a_s10;
		s.neg   = neg_s10;
		s.pmag  = pmag_s10;
		s.dmag  = dmag_s10;
	end

endmodule

// ----- design/lcp_div.sv -----
module lcp_div import lcp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  scale_t s,
	output res_t   r
);

	localparam logic [COORD_W:0] QLIM = {1'b1, {COORD_W{1'b0}}};
	localparam logic signed [SUM_W-1:0] CMAX = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] CMIN = -CMAX - SUM_W'(1);

	// Index 0 is the overflow precheck; index k resolves quotient bit Q_BITS-k.
	logic                      vld_s [0:Q_BITS];
	status_t                   rej_s [0:Q_BITS];
	logic signed [COORD_W-1:0] a_s   [0:Q_BITS][3];
	logic                      neg_s [0:Q_BITS][3];
	logic                      sat_s [0:Q_BITS][3];
	logic [DIV_W-1:0]          rem_s [0:Q_BITS][3];
	logic [Q_BITS-1:0]         q_s   [0:Q_BITS][3];
	logic [DEN_W-1:0]          d_s   [0:Q_BITS];

	logic                      vld_sr, vld_so;
	status_t                   rej_sr, st_so;
	logic signed [COORD_W-1:0] a_sr [3], pt_so [3];
	logic                      neg_sr [3];
	logic [COORD_W:0]          qm_sr [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= s.valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rem_s[0][i] <= DIV_W'(s.pmag[i]);
			sat_s[0][i] <= DIV_W'(s.pmag[i]) >= (DIV_W'(s.dmag) << Q_BITS);
			q_s[0][i]   <= '0;
		end
		d_s[0]   <= s.dmag;
		rej_s[0] <= s.rej;
		a_s[0]   <= s.a;
		neg_s[0] <= s.neg;
	end

	for (genvar k = 1; k <= Q_BITS; k++) begin : g_bit
		logic [DIV_W-1:0] dsh;
		logic             ge [3];

		always_comb begin
			dsh = DIV_W'(d_s[k-1]) << (Q_BITS - k);
			for (int i = 0; i < 3; i++) begin
				ge[i] = rem_s[k-1][i] >= dsh;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				rem_s[k][i] <= ge[i] ? rem_s[k-1][i] - dsh : rem_s[k-1][i];
				q_s[k][i]   <= q_s[k-1][i] | (Q_BITS'(ge[i]) << (Q_BITS - k));
			end
			d_s[k]   <= d_s[k-1];
			rej_s[k] <= rej_s[k-1];
			a_s[k]   <= a_s[k-1];
			neg_s[k] <= neg_s[k-1];
			sat_s[k] <= sat_s[k-1];
		end
	end

	// Round half up on the magnitude, then limit the offset to 2^COORD_W.
	logic [Q_BITS:0] qr [3];
	logic            rbit [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rbit[i] = {rem_s[Q_BITS][i][DEN_W-1:0], 1'b0} >= {1'b0, d_s[Q_BITS]};
			qr[i] = {1'b0, q_s[Q_BITS][i]} + (Q_BITS + 1)'(rbit[i]);
		end
	end

	// Final add and clamp to the coordinate range; a rejected word gives the origin and its reject status.
	logic signed [SUM_W-1:0]   sum [3];
	logic signed [COORD_W-1:0] pt [3];
	logic                      clip [3];
	status_t                   st;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = SUM_W'(a_sr[i]) + (neg_sr[i] ? -SUM_W'($signed({1'b0, qm_sr[i]}))
				: SUM_W'($signed({1'b0, qm_sr[i]})));
			clip[i] = 1'b1;
			if (sum[i] > CMAX) begin
				pt[i] = CMAX[COORD_W-1:0];
			end else if (sum[i] < CMIN) begin
				pt[i] = CMIN[COORD_W-1:0];
			end else begin
				pt[i] = sum[i][COORD_W-1:0];
				clip[i] = 1'b0;
			end
		end
		if (rej_sr != ST_OK) begin
			st = rej_sr;
			for (int i = 0; i < 3; i++) begin
				pt[i] = '0;
			end
		end else if (clip[0] || clip[1] || clip[2]) begin
			st = ST_SAT;
		end else begin
			st = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sr <= 1'b0;
			vld_so <= 1'b0;
		end else begin
			vld_sr <= vld_s[Q_BITS];
			vld_so <= vld_sr;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (sat_s[Q_BITS][i] || qr[i] > (Q_BITS + 1)'(QLIM)) begin
				qm_sr[i] <= QLIM;
			end else begin
				qm_sr[i] <= qr[i][COORD_W:0];
			end
		end
		rej_sr <= rej_s[Q_BITS];
		a_sr   <= a_s[Q_BITS];
		neg_sr <= neg_s[Q_BITS];
		pt_so  <= pt;
		st_so  <= st;
	end

	always_comb begin
		r.valid  = vld_so;
		r.point  = pt_so;
		r.status = st_so;
	end

endmodule

// ----- design/line_line_closest_point_3d_top.sv -----
// Closest point on line 1 to line 2. Each word carries a point and a unit direction
// for both lines; the result word is the point on line 1 nearest line 2 and a status.
// A word is taken on every clock where start is high (busy stays low), and its result
// appears on done, one result per word in order. The divider is a restoring pipeline
// that resolves one quotient bit per stage (33 stages), behind ten stages of multiplies
// and sums. done is high for one cycle and the result must be captured then. The
// parallel threshold is written through cfg_data with cfg_valid (cfg_ready is always
// high) and should change only while no word is in flight.
module line_line_closest_point_3d_top import lcp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_W-1:0] pos1_x,
	input  logic signed [COORD_W-1:0] pos1_y,
	input  logic signed [COORD_W-1:0] pos1_z,
	input  logic signed [DIR_W-1:0]   dir1_x,
	input  logic signed [DIR_W-1:0]   dir1_y,
	input  logic signed [DIR_W-1:0]   dir1_z,
	input  logic signed [COORD_W-1:0] pos2_x,
	input  logic signed [COORD_W-1:0] pos2_y,
	input  logic signed [COORD_W-1:0] pos2_z,
	input  logic signed [DIR_W-1:0]   dir2_x,
	input  logic signed [DIR_W-1:0]   dir2_y,
	input  logic signed [DIR_W-1:0]   dir2_z,
	output logic                      done,
	output logic signed [COORD_W-1:0] point_x,
	output logic signed [COORD_W-1:0] point_y,
	output logic signed [COORD_W-1:0] point_z,
	output logic [1:0]                status,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [THR_W-1:0]          cfg_data
);

	logic [THR_W-1:0] thr_q;

	logic signed [COORD_W-1:0] pos_a [3], pos_b [3];
	logic signed [DIR_W-1:0]   dir_v [3], dir_w [3];
	front_t f;
	scale_t s;
	res_t   r;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	always_comb begin
		pos_a[0] = pos1_x;
		pos_a[1] = pos1_y;
		pos_a[2] = pos1_z;
		dir_v[0] = dir1_x;
		dir_v[1] = dir1_y;
		dir_v[2] = dir1_z;
		pos_b[0] = pos2_x;
		pos_b[1] = pos2_y;
		pos_b[2] = pos2_z;
		dir_w[0] = dir2_x;
		dir_w[1] = dir2_y;
		dir_w[2] = dir2_z;
	end

	lcp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.pos_a    (pos_a),
		.dir_v    (dir_v),
		.pos_b    (pos_b),
		.dir_w    (dir_w),
		.thr      (thr_q),
		.f        (f)
	);

	lcp_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.f      (f),
		.s      (s)
	);

	lcp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.s      (s),
		.r      (r)
	);

	assign done    = r.valid;
	assign point_x = r.point[0];
	assign point_y = r.point[1];
	assign point_z = r.point[2];
	assign status  = r.status;

endmodule

// ----- design/lcp_checker.sv -----
module lcp_checker import lcp_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic signed [COORD_W-1:0] point_x,
	input logic signed [COORD_W-1:0] point_y,
	input logic signed [COORD_W-1:0] point_z,
	input logic [1:0]                status
);

	// Every accepted word produces its result after the fixed pipeline latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted word produced no result");

	// No result appears without a word accepted the matching number of cycles before.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching input word");

	// Rejected pairs report the origin.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_PARALLEL || status == ST_ZERO_DIV))
		|-> (point_x == '0 && point_y == '0 && point_z == '0))
		else $error("rejected pair with nonzero point");

endmodule

bind line_line_closest_point_3d_top lcp_checker u_lcp_checker (.*);
